// ===== design/trd_pkg.sv =====
// trd_pkg: shared types and constants for the tls record deframer
// used by trd_cfg, trd_parse, trd_outbuf and tls_record_deframer
package trd_pkg;

  localparam logic [7:0]  TYPE_LOW       = 8'd19;
  localparam logic [7:0]  TYPE_HIGH      = 8'd27;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd16640;

  localparam logic [1:0]  ERR_NONE       = 2'd0;
  localparam logic [1:0]  ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0]  ERR_OVERFLOW   = 2'd2;

  localparam int          CFG_AW         = 3;
  localparam logic        REG_MAX_LEN    = 1'b0;

  typedef struct packed {
    logic [7:0] record_type;
    logic [7:0] version_major;
    logic [7:0] version_minor;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       end_of_record;
    logic [1:0] error_code;
  } trd_result_t;

endpackage

// ===== design/trd_cfg.sv =====
// trd_cfg: apb-style register file holding the maximum payload length
// depends on trd_pkg
module trd_cfg import trd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [15:0]       max_len
);

  logic [15:0] max_len_r;
  logic        wr_en;

  // register index is the word address
  assign wr_en  = psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_MAX_LEN);
  assign pready = 1'b1;
  assign max_len = max_len_r;

  always_comb begin
    if (paddr[CFG_AW-1:2] == REG_MAX_LEN) begin
      prdata = {16'd0, max_len_r};
    end else begin
      prdata = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (wr_en) begin
      max_len_r <= pwdata[15:0];
    end
  end

endmodule

// ===== design/trd_parse.sv =====
// trd_parse: per-byte record header/payload state machine
// depends on trd_pkg; produces at most one result per accepted byte
module trd_parse import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic [15:0] max_len,
  output logic        res_valid,
  output trd_result_t res
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DEAD    = 2'd2;

  localparam logic [2:0] HDR_TYPE   = 3'd0;
  localparam logic [2:0] HDR_MAJOR  = 3'd1;
  localparam logic [2:0] HDR_MINOR  = 3'd2;
  localparam logic [2:0] HDR_LEN_HI = 3'd3;
  localparam logic [2:0] HDR_LEN_LO = 3'd4;

  logic [1:0]  phase_r,     phase_nxt;
  logic [2:0]  hdr_idx_r,   hdr_idx_nxt;
  logic [7:0]  type_r,      type_nxt;
  logic [7:0]  major_r,     major_nxt;
  logic [7:0]  minor_r,     minor_nxt;
  logic [7:0]  len_hi_r,    len_hi_nxt;
  logic [15:0] left_r,      left_nxt;
  logic [15:0] rec_len;

  assign rec_len = {len_hi_r, in_byte};

  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    type_nxt    = type_r;
    major_nxt   = major_r;
    minor_nxt   = minor_r;
    len_hi_nxt  = len_hi_r;
    left_nxt    = left_r;
    res_valid   = 1'b0;
    res.record_type   = type_r;
    res.version_major = major_r;
    res.version_minor = minor_r;
    res.payload_byte  = 8'd0;
    res.has_byte      = 1'b0;
    res.end_of_record = 1'b0;
    res.error_code    = ERR_NONE;

    unique case (phase_r)
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.payload_byte  = in_byte;
        res.has_byte      = 1'b1;
        left_nxt          = left_r - 16'd1;
        if (left_r == 16'd1) begin
          res.end_of_record = 1'b1;
          phase_nxt         = PH_HEADER;
          hdr_idx_nxt       = HDR_TYPE;
        end
      end
      PH_HEADER: begin
        unique case (hdr_idx_r)
          HDR_TYPE: begin
            if ((in_byte < TYPE_LOW) || (in_byte > TYPE_HIGH)) begin
              res_valid         = 1'b1;
              res.record_type   = in_byte;
              res.version_major = 8'd0;
              res.version_minor = 8'd0;
              res.error_code    = ERR_UNEXPECTED;
              phase_nxt         = PH_DEAD;
            end else begin
              type_nxt    = in_byte;
              hdr_idx_nxt = HDR_MAJOR;
            end
          end
          HDR_MAJOR: begin
            major_nxt   = in_byte;
            hdr_idx_nxt = HDR_MINOR;
          end
          HDR_MINOR: begin
            minor_nxt   = in_byte;
            hdr_idx_nxt = HDR_LEN_HI;
          end
          HDR_LEN_HI: begin
            len_hi_nxt  = in_byte;
            hdr_idx_nxt = HDR_LEN_LO;
          end
          default: begin
            // low length byte completes the header
            hdr_idx_nxt = HDR_TYPE;
            if (rec_len > max_len) begin
              res_valid      = 1'b1;
              res.error_code = ERR_OVERFLOW;
              phase_nxt      = PH_DEAD;
            end else if (rec_len == 16'd0) begin
              res_valid         = 1'b1;
              res.end_of_record = 1'b1;
            end else begin
              left_nxt  = rec_len;
              phase_nxt = PH_PAYLOAD;
            end
          end
        endcase
      end
      default: begin
        // dead: swallow everything until reset
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= HDR_TYPE;
      type_r    <= 8'd0;
      major_r   <= 8'd0;
      minor_r   <= 8'd0;
      len_hi_r  <= 8'd0;
      left_r    <= 16'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      type_r    <= type_nxt;
      major_r   <= major_nxt;
      minor_r   <= minor_nxt;
      len_hi_r  <= len_hi_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

// ===== design/trd_outbuf.sv =====
// trd_outbuf: result register with a skid stage behind it
// depends on trd_pkg; full skid stage holds off the input side
module trd_outbuf import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  trd_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output trd_result_t out_data
);

  logic        main_vld_r;
  logic        skid_vld_r;
  trd_result_t main_r;
  trd_result_t skid_r;
  logic        pop;

  assign pop       = main_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  // push only happens while the skid stage is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= skid_vld_r;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_vld_r || pop) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end else if (pop && skid_vld_r) begin
      main_r <= skid_r;
    end
  end

endmodule

// ===== design/tls_record_deframer.sv =====
// tls_record_deframer: splits a received byte stream into records
// depends on trd_pkg, trd_cfg, trd_parse and trd_outbuf
//
// usage:
//   input channel: one stream byte per transaction on in_byte, handshake
//   in_valid / in_stall. result channel: header fields plus at most one
//   payload byte per transaction, handshake out_valid / out_stall.
//   register 0 (byte address 0) holds max_payload_length, reset 16640,
//   reachable through the apb-style port with pready tied high.
// timing:
//   one byte is taken every cycle while in_stall is low; the byte is parsed
//   in the cycle it is taken, and any result is registered in trd_outbuf.
//   header bytes give no result except on an error or an empty record.
// stall:
//   while out_stall is high the result register holds and one further
//   result goes into a skid stage; once that is full in_stall rises until
//   the receiver drains it, so nothing is lost or repeated.
// reset:
//   rst_n low clears the parser to expect a header and empties both output
//   stages. after an error result the block drops all input until reset.
module tls_record_deframer import trd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_record_type,
  output logic [7:0]        out_version_major,
  output logic [7:0]        out_version_minor,
  output logic [7:0]        out_payload_byte,
  output logic              out_has_byte,
  output logic              out_end_of_record,
  output logic [1:0]        out_error_code,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        accept;
  logic        res_valid;
  logic        buf_full;
  logic [15:0] max_len;
  trd_result_t res;
  trd_result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  trd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  trd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .max_len   (max_len),
    .res_valid (res_valid),
    .res       (res)
  );

  trd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_record_type   = out_data.record_type;
  assign out_version_major = out_data.version_major;
  assign out_version_minor = out_data.version_minor;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_has_byte      = out_data.has_byte;
  assign out_end_of_record = out_data.end_of_record;
  assign out_error_code    = out_data.error_code;

endmodule
